@@ hdl/lpp_pkg.sv @@
package lpp_pkg;

  localparam int MAX_SAMPLES    = 32;
  localparam int NODES_PER_SCAN = 10;
  localparam int ADDR_W         = $clog2(MAX_SAMPLES);

  localparam logic [7:0] SYNC_A         = 8'hCE;
  localparam logic [7:0] SYNC_B         = 8'hFA;
  localparam logic [7:0] MIN_PACKET_LEN = 8'd10;
  localparam logic [7:0] HEADER_BYTES   = 8'd6;

  // floor(a / 360) = floor((a >> 3) * 11651 / 2^19) for every 16-bit a
  localparam logic [13:0] NODE_RECIP = 14'd11651;
  localparam int          NODE_SHIFT = 19;

  typedef enum logic [2:0] {
    ST_RX,
    ST_CHECK,
    ST_ERR,
    ST_READ,
    ST_SAMPLE
  } state_t;

  typedef enum logic [2:0] {
    PKT_OK,
    PKT_SHORT,
    PKT_LENGTH,
    PKT_CHECKSUM,
    PKT_NODE
  } pkt_status_t;

  typedef enum logic [1:0] {
    SCAN_NONE,
    SCAN_FULL,
    SCAN_INCOMPLETE
  } scan_status_t;

endpackage

@@ hdl/lidar_packet_parser.sv @@
// lidar packet parser: takes the lidar serial stream one byte per item and
// splits it into packets at each 0xCE 0xFA sync pair. Packet bytes are taken one
// item late, so a 0xCE that opens the next sync is never read as data. Distance
// words go into a 32-entry sample memory; the count, angle, running checksum and
// checksum word sit in registers. A packet closes when the next sync pair
// arrives: the block then stops taking bytes, runs the length, checksum and
// node checks in its check state, and emits either one error item or one item
// per sample, reading the memory one entry at a time (a read state and an
// output state per sample; the output state waits out any output stall). While
// a packet is being received and no closed packet is being handled, a byte is
// taken every cycle. Node index is start angle / 360, capped at 15 in the
// result; ok packets mark nodes of the scan, and the last item at the final
// node says whether the whole scan was seen.
module lidar_packet_parser
  import lpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [12:0] distance, [17:13] sample_index,
                                      // [18] sample_valid, [22:19] node_index,
                                      // [38:23] start_angle, [54:39] sample_count,
                                      // [57:55] packet_status, [59:58] scan_status,
                                      // [63:60] zero
  output logic        m_axis_tlast    // last item of the packet run
);

  state_t state, state_next;

  // packet parse registers
  logic        in_packet;
  logic [7:0]  prev_byte;
  logic [7:0]  byte_pos;
  logic        overflow;
  logic [15:0] count_field;
  logic [15:0] angle_field;
  logic [15:0] sum_acc;
  logic [15:0] check_word;
  logic [7:0]  lo_byte;

  // node tracking
  logic [26:0]               node_prod;
  logic [7:0]                node_q;
  logic [3:0]                node_out;
  logic [NODES_PER_SCAN-1:0] node_seen;
  logic [NODES_PER_SCAN-1:0] seen_new;

  // close handling
  pkt_status_t  status_q, status_calc;
  scan_status_t scan_q;
  logic [ADDR_W-1:0] k;
  logic              k_last;

  // sample memory
  logic [12:0] mem [MAX_SAMPLES];
  logic [12:0] rd_data;
  logic        mem_we;
  logic [ADDR_W-1:0] mem_waddr;

  logic        in_acc, out_acc, sync, finish;
  logic [7:0]  off;
  logic [6:0]  w;
  logic        hi;
  logic        w_in_count, w_is_check, w_stored;
  logic [17:0] exp_len;
  logic [15:0] csum;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign sync    = (prev_byte == SYNC_A) && (s_axis_tdata == SYNC_B);

  // data byte decode: offset past the header, word number and byte half
  assign off        = byte_pos - HEADER_BYTES;
  assign w          = off[7:1];
  assign hi         = off[0];
  assign w_in_count = {9'd0, w} < count_field;
  assign w_is_check = {9'd0, w} == count_field;
  assign w_stored   = w < 7'(MAX_SAMPLES);

  assign mem_we    = in_acc && in_packet && !sync && (byte_pos >= HEADER_BYTES)
                     && w_in_count && w_stored && hi;
  assign mem_waddr = w[ADDR_W-1:0];

  // angle / 360 by reciprocal multiply, registered
  assign node_prod = angle_field[15:3] * NODE_RECIP;
  assign node_out  = (node_q > 8'd15) ? 4'd15 : node_q[3:0];

  // close checks
  assign exp_len = {1'b0, count_field, 1'b0} + 18'd8;
  assign csum    = 16'(sum_acc + count_field + angle_field);

  always_comb begin
    if (byte_pos < MIN_PACKET_LEN) begin
      status_calc = PKT_SHORT;
    end else if ({10'd0, byte_pos} != exp_len || overflow) begin
      status_calc = PKT_LENGTH;
    end else if (csum != check_word) begin
      status_calc = PKT_CHECKSUM;
    end else if (node_q >= 8'(NODES_PER_SCAN)) begin
      status_calc = PKT_NODE;
    end else begin
      status_calc = PKT_OK;
    end
  end

  // node 0 starts a new scan
  always_comb begin
    seen_new = (node_q == 8'd0) ? '0 : node_seen;
    for (int i = 0; i < NODES_PER_SCAN; i++) begin
      if (node_q == 8'(i)) begin
        seen_new[i] = 1'b1;
      end
    end
  end

  assign k_last = (k == ADDR_W'(count_field - 16'd1));
  assign finish = out_acc && m_axis_tlast;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_RX: begin
        if (in_acc && in_packet && sync) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = (status_calc == PKT_OK) ? ST_READ : ST_ERR;
      end
      ST_ERR: begin
        if (out_acc) begin
          state_next = ST_RX;
        end
      end
      ST_READ: begin
        state_next = ST_SAMPLE;
      end
      ST_SAMPLE: begin
        if (out_acc) begin
          state_next = k_last ? ST_RX : ST_READ;
        end
      end
      default: begin
        state_next = ST_RX;
      end
    endcase
  end

  // handshake and result fields
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    m_axis_tlast  = 1'b0;
    m_axis_tdata  = '0;
    m_axis_tdata[22:19] = node_out;
    m_axis_tdata[38:23] = angle_field;
    m_axis_tdata[54:39] = count_field;
    m_axis_tdata[57:55] = status_q;
    case (state)
      ST_RX: begin
        s_axis_tready = 1'b1;
      end
      ST_ERR: begin
        m_axis_tvalid = 1'b1;
        m_axis_tlast  = 1'b1;
      end
      ST_SAMPLE: begin
        m_axis_tvalid       = 1'b1;
        m_axis_tlast        = k_last;
        m_axis_tdata[12:0]  = rd_data;
        m_axis_tdata[17:13] = 5'(k);
        m_axis_tdata[18]    = 1'b1;
        m_axis_tdata[59:58] = k_last ? scan_q : SCAN_NONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RX;
      in_packet   <= 1'b0;
      prev_byte   <= '0;
      byte_pos    <= '0;
      overflow    <= 1'b0;
      count_field <= '0;
      angle_field <= '0;
      sum_acc     <= '0;
      check_word  <= '0;
      node_seen   <= '0;
      status_q    <= PKT_OK;
      scan_q      <= SCAN_NONE;
      k           <= '0;
    end else begin
      state <= state_next;

      if (in_acc) begin
        prev_byte <= s_axis_tdata;
        if (!in_packet && sync) begin
          in_packet   <= 1'b1;
          byte_pos    <= 8'd1;
          overflow    <= 1'b0;
          count_field <= '0;
          angle_field <= '0;
          sum_acc     <= '0;
          check_word  <= '0;
        end else if (in_packet && !sync) begin
          if (byte_pos != 8'd255) begin
            byte_pos <= byte_pos + 8'd1;
          end
          case (byte_pos)
            8'd2: count_field <= {8'd0, prev_byte};
            8'd3: begin
              count_field <= {prev_byte, count_field[7:0]};
              overflow    <= {prev_byte, count_field[7:0]} > 16'(MAX_SAMPLES);
            end
            8'd4: angle_field <= {8'd0, prev_byte};
            8'd5: angle_field <= {prev_byte, angle_field[7:0]};
            default: begin
              if (byte_pos >= HEADER_BYTES) begin
                if (w_in_count) begin
                  sum_acc <= hi ? sum_acc + {prev_byte, 8'd0}
                                : sum_acc + {8'd0, prev_byte};
                end else if (w_is_check) begin
                  check_word <= hi ? {prev_byte, check_word[7:0]}
                                   : {8'd0, prev_byte};
                end
              end
            end
          endcase
        end
      end

      if (state == ST_CHECK) begin
        status_q <= status_calc;
        k        <= '0;
        scan_q   <= SCAN_NONE;
        if (status_calc == PKT_OK) begin
          if (node_q == 8'(NODES_PER_SCAN - 1)) begin
            scan_q    <= (&seen_new) ? SCAN_FULL : SCAN_INCOMPLETE;
            node_seen <= '0;
          end else begin
            node_seen <= seen_new;
          end
        end
      end

      if (state == ST_SAMPLE && out_acc && !k_last) begin
        k <= k + ADDR_W'(1);
      end

      // the closing sync pair opens the next packet once the run is out
      if (finish) begin
        byte_pos    <= 8'd1;
        overflow    <= 1'b0;
        count_field <= '0;
        angle_field <= '0;
        sum_acc     <= '0;
        check_word  <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    node_q <= node_prod[26:NODE_SHIFT];
    if (in_acc && in_packet && !sync && (byte_pos >= HEADER_BYTES) && !hi) begin
      lo_byte <= prev_byte;
    end
  end

  // sample memory: written while receiving, read only while input is held
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= {prev_byte[4:0], lo_byte};
    end
    if (state == ST_READ) begin
      rd_data <= mem[k];
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while a result is pending");

  a_sample_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[18]) |-> (m_axis_tdata[57:55] == PKT_OK))
    else $error("sample item carries an error status");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[18]) |-> m_axis_tlast)
    else $error("error item not marked last");

  a_scan_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[59:58] == SCAN_NONE))
    else $error("scan status before last item");

  a_check_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |=> (state == ST_READ || state == ST_ERR))
    else $error("close check did not resolve");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !mem_we)
    else $error("sample memory written during readout");
`endif

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  import lpp_pkg::*;

  localparam int DEG_PER_NODE = 360;
  localparam int HOLD_CYCLES  = 400;
  localparam int REPORT_LIMIT = 10;

  // one result item as it leaves the parser, lowest field last
  typedef struct packed {
    logic [12:0]  distance;
    logic [4:0]   sample_index;
    logic         sample_valid;
    logic [3:0]   node_index;
    logic [15:0]  start_angle;
    logic [15:0]  sample_count;
    pkt_status_t  packet_status;
    scan_status_t scan_status;
    logic         last;
  } sample_rec_t;

  // ways a generated packet can be spoiled
  typedef enum int {
    FLAW_NONE,
    FLAW_SUM,
    FLAW_DROP,
    FLAW_EXTRA,
    FLAW_RUNON,
    FLAW_NOISE
  } flaw_t;

  typedef enum int {
    FILL_RAND,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  typedef struct {
    flaw_t       flaw;
    int          words;
    logic [15:0] count;
    logic [15:0] angle;
    fill_t       fill;
    logic        want_on;
    pkt_status_t want;
  } plan_row_t;

  // directed packets; status typed in where it is plain from the header
  plan_row_t plan [14] = '{
    '{FLAW_NOISE, 6,  16'd0,     16'd0,     FILL_RAND, 1'b0, PKT_OK},       // hunting bytes
    '{FLAW_NONE,  1,  16'd1,     16'd0,     FILL_ZERO, 1'b1, PKT_OK},
    '{FLAW_NONE,  1,  16'd1,     16'd359,   FILL_ONES, 1'b1, PKT_OK},
    '{FLAW_NONE,  32, 16'd32,    16'd360,   FILL_RAND, 1'b1, PKT_OK},       // full store
    '{FLAW_NONE,  0,  16'd0,     16'd720,   FILL_RAND, 1'b1, PKT_SHORT},
    '{FLAW_SUM,   2,  16'd2,     16'd1080,  FILL_RAND, 1'b1, PKT_CHECKSUM},
    '{FLAW_DROP,  3,  16'd3,     16'd1440,  FILL_RAND, 1'b1, PKT_LENGTH},
    '{FLAW_EXTRA, 3,  16'd3,     16'd1800,  FILL_RAND, 1'b1, PKT_LENGTH},
    '{FLAW_NONE,  33, 16'd33,    16'd2160,  FILL_RAND, 1'b1, PKT_LENGTH},   // count overflow
    '{FLAW_NONE,  2,  16'hFFFF,  16'd2520,  FILL_RAND, 1'b1, PKT_LENGTH},
    '{FLAW_NONE,  1,  16'd1,     16'd3600,  FILL_RAND, 1'b1, PKT_NODE},
    '{FLAW_NONE,  1,  16'd1,     16'hFFFF,  FILL_ONES, 1'b1, PKT_NODE},
    '{FLAW_RUNON, 4,  16'd4,     16'd2880,  FILL_RAND, 1'b1, PKT_LENGTH},   // length saturates
    '{FLAW_NONE,  2,  16'd2,     16'd3599,  FILL_RAND, 1'b1, PKT_OK}        // last node, gaps
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = 8'h00;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [63:0] m_data;
  logic        m_last;

  // parser image
  logic                      rx_open = 1'b0;
  logic [7:0]                last_byte = 8'h00;
  logic [7:0]                byte_pos = 8'h00;
  logic                      cnt_over = 1'b0;
  logic [15:0]               hdr_count = 16'h0000;
  logic [15:0]               hdr_angle = 16'h0000;
  logic [15:0]               run_sum = 16'h0000;
  logic [15:0]               sum_word = 16'h0000;
  logic [12:0]               dist_mem [MAX_SAMPLES] = '{default: '0};
  logic [NODES_PER_SCAN-1:0] nodes_seen = '0;

  // typed packet status, handed from the plan to the packet that opens next
  logic        next_want_on = 1'b0;
  pkt_status_t next_want = PKT_OK;
  logic        open_want_on = 1'b0;
  pkt_status_t open_want = PKT_OK;

  sample_rec_t samples_due [$];
  int          bad = 0;
  int          bytes_sent = 0;
  int          results_made = 0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;

  lidar_packet_parser uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last)
  );

  always #6 clk = ~clk;

  function automatic string rec_text(input sample_rec_t r);
    return $sformatf("dist %0d idx %0d valid %0d node %0d angle %0d count %0d status %0d scan %0d last %0d",
                     r.distance, r.sample_index, r.sample_valid, r.node_index, r.start_angle,
                     r.sample_count, r.packet_status, r.scan_status, r.last);
  endfunction

  // advance the parser image by one accepted byte, queue what a closing packet emits
  task automatic parse_byte(input logic [7:0] b);
    logic         is_sync;
    int           len;
    int           n;
    int           node;
    int           p;
    int           off;
    int           w;
    int           k;
    pkt_status_t  st;
    scan_status_t scan;
    sample_rec_t  rec;
    is_sync = (last_byte == SYNC_A) && (b == SYNC_B);
    if (rx_open && is_sync) begin
      len  = byte_pos;
      n    = hdr_count;
      node = hdr_angle / DEG_PER_NODE;
      if (len < MIN_PACKET_LEN) st = PKT_SHORT;
      else if (len != 8 + 2 * n || cnt_over) st = PKT_LENGTH;
      else if (16'(run_sum + hdr_count + hdr_angle) != sum_word) st = PKT_CHECKSUM;
      else if (node >= NODES_PER_SCAN) st = PKT_NODE;
      else st = PKT_OK;
      rec = '0;
      rec.node_index    = (node > 15) ? 4'd15 : 4'(node);
      rec.start_angle   = hdr_angle;
      rec.sample_count  = hdr_count;
      rec.packet_status = open_want_on ? open_want : st;
      if (st != PKT_OK) begin
        rec.scan_status = SCAN_NONE;
        rec.last        = 1'b1;
        samples_due.push_back(rec);
        results_made++;
      end else begin
        // node 0 starts a fresh scan, the last node reports and clears it
        scan = SCAN_NONE;
        if (node == 0) nodes_seen = '0;
        nodes_seen[node] = 1'b1;
        if (node == NODES_PER_SCAN - 1) begin
          scan = (&nodes_seen) ? SCAN_FULL : SCAN_INCOMPLETE;
          nodes_seen = '0;
        end
        for (k = 0; k < n; k++) begin
          rec.distance     = dist_mem[k];
          rec.sample_index = 5'(k);
          rec.sample_valid = 1'b1;
          rec.last         = (k == n - 1);
          rec.scan_status  = rec.last ? scan : SCAN_NONE;
          samples_due.push_back(rec);
          results_made++;
        end
      end
    end
    if (is_sync) begin
      rx_open      = 1'b1;
      byte_pos     = 8'd1;
      cnt_over     = 1'b0;
      hdr_count    = '0;
      hdr_angle    = '0;
      run_sum      = '0;
      sum_word     = '0;
      open_want    = next_want;
      open_want_on = next_want_on;
      next_want_on = 1'b0;
    end else if (rx_open) begin
      // bytes land one item late, so a 0xCE opening the next sync is never data
      p = byte_pos;
      case (p)
        2: hdr_count = {8'h00, last_byte};
        3: begin
          hdr_count[15:8] = last_byte;
          cnt_over = (hdr_count > MAX_SAMPLES);
        end
        4: hdr_angle = {8'h00, last_byte};
        5: hdr_angle[15:8] = last_byte;
        default: begin
          if (p >= 6) begin
            off = p - 6;
            w   = off >> 1;
            if (w < hdr_count) begin
              if (off[0]) begin
                run_sum += {last_byte, 8'h00};
                if (w < MAX_SAMPLES) dist_mem[w][12:8] = last_byte[4:0];
              end else begin
                run_sum += {8'h00, last_byte};
                if (w < MAX_SAMPLES) dist_mem[w] = {5'b00000, last_byte};
              end
            end else if (w == hdr_count) begin
              if (off[0]) sum_word[15:8] = last_byte;
              else sum_word = {8'h00, last_byte};
            end
          end
        end
      endcase
      if (byte_pos != 8'hFF) byte_pos++;
    end
    last_byte = b;
  endtask

  // offer one byte, with random idle cycles ahead of it
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    bytes_sent++;
    parse_byte(b);
  endtask

  // sync, header, distance words, checksum, then the chosen spoiling; a noise flaw sends only random bytes
  task automatic send_packet(input flaw_t flaw, input int words, input logic [15:0] count,
                             input logic [15:0] angle, input fill_t fill);
    logic [7:0]  body [$];
    logic [15:0] w;
    logic [15:0] sum;
    int          i;
    if (flaw == FLAW_NOISE) begin
      repeat (words) push_byte(8'($urandom_range(8'hCD)));
      return;
    end
    body = '{count[7:0], count[15:8], angle[7:0], angle[15:8]};
    sum  = count + angle;
    for (i = 0; i < words; i++) begin
      case (fill)
        FILL_ZERO: w = 16'h0000;
        FILL_ONES: w = 16'hFFFF;
        default:   w = 16'($urandom);
      endcase
      body.push_back(w[7:0]);
      body.push_back(w[15:8]);
      sum += w;
    end
    if (flaw == FLAW_SUM) sum ^= 16'h0001 << $urandom_range(15);
    body.push_back(sum[7:0]);
    body.push_back(sum[15:8]);
    case (flaw)
      FLAW_DROP:  void'(body.pop_back());
      FLAW_EXTRA: body.push_back(8'($urandom_range(8'hCD)));
      FLAW_RUNON: repeat (300) body.push_back(8'($urandom_range(8'hCD)));
      default: ;
    endcase
    // a stray sync pair inside the body splits the packet, typed status no longer holds
    for (i = 1; i < body.size(); i++)
      if (body[i-1] == SYNC_A && body[i] == SYNC_B) next_want_on = 1'b0;
    push_byte(SYNC_A);
    push_byte(SYNC_B);
    foreach (body[j]) push_byte(body[j]);
  endtask

  // result side: compare, then pick the ready for the next cycle
  always @(posedge clk) begin : sink
    sample_rec_t got;
    sample_rec_t want;
    if (!rst) begin
      if (m_valid && m_ready) begin
        got = {m_data[12:0], m_data[17:13], m_data[18], m_data[22:19], m_data[38:23],
               m_data[54:39], m_data[57:55], m_data[59:58], m_last};
        if (samples_due.size() == 0) begin
          bad++;
          if (bad <= REPORT_LIMIT) $display("unexpected result: %s", rec_text(got));
        end else begin
          want = samples_due.pop_front();
          if (got !== want) begin
            bad++;
            if (bad <= REPORT_LIMIT)
              $display("result mismatch\n  want %s\n  got  %s", rec_text(want), rec_text(got));
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  initial begin : stimulus
    int          i;
    int          n;
    int          node;
    int          skip;
    int          b0;
    int          r0;
    logic [15:0] cnt;
    logic [15:0] ang;
    flaw_t       flaw;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed packets, each closed by the sync of the one after it
    for (i = 0; i < $size(plan); i++) begin
      next_want    = plan[i].want;
      next_want_on = plan[i].want_on;
      send_packet(plan[i].flaw, plan[i].words, plan[i].count, plan[i].angle, plan[i].fill);
    end

    // long receiver hold while two packets keep coming, so the input backs up
    hold_req = 1'b1;
    send_packet(FLAW_NONE, 8, 16'd8, 16'(2 * DEG_PER_NODE + $urandom_range(359)), FILL_RAND);
    send_packet(FLAW_NONE, 8, 16'd8, 16'(3 * DEG_PER_NODE + $urandom_range(359)), FILL_RAND);
    push_byte(SYNC_A);
    push_byte(SYNC_B);
    // sender stays quiet until the parser has drained
    s_valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);

    // random scans: mostly clean packets in node order, some spoiled
    b0 = bytes_sent;
    r0 = results_made;
    while ((bytes_sent - b0) < 180 || (results_made - r0) < 48) begin
      skip = ($urandom_range(1) == 0) ? -1 : int'($urandom_range(8));
      for (node = 0; node < NODES_PER_SCAN; node++) begin
        case (((bytes_sent - b0) * 4) / 180)
          0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
          1: begin src_idle_pct = 81; snk_stall_pct = 0;  end
          2: begin src_idle_pct = 0;  snk_stall_pct = 81; end
          default: begin src_idle_pct = 33; snk_stall_pct = 33; end
        endcase
        if (node == skip) continue;
        n    = ($urandom_range(19) == 0) ? MAX_SAMPLES : int'($urandom_range(4, 1));
        cnt  = 16'(n);
        ang  = 16'(node * DEG_PER_NODE + $urandom_range(359));
        flaw = FLAW_NONE;
        if ($urandom_range(99) < 20) begin
          case ($urandom_range(5))
            0: flaw = FLAW_SUM;
            1: flaw = FLAW_DROP;
            2: flaw = FLAW_EXTRA;
            3: ang = 16'($urandom_range(65535, 3600));
            4: begin
              cnt = 16'($urandom);
              n   = $urandom_range(6);
            end
            default: send_packet(FLAW_NOISE, $urandom_range(4, 1), 16'd0, 16'd0, FILL_RAND);
          endcase
        end
        send_packet(flaw, n, cnt, ang, FILL_RAND);
      end
    end

    // closing sync for the last packet, then drain
    push_byte(SYNC_A);
    push_byte(SYNC_B);
    s_valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (bad == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ lidar_packet_parser.f @@
hdl/lpp_pkg.sv
hdl/lidar_packet_parser.sv
verif/tb_top.sv
